// File: rtl/bit_pkg.sv
`timescale 1ns / 1ps
// bit_pkg: shared constants and helpers for binary_image_thinning.
// Used by bit_pix and binary_image_thinning.
package bit_pkg;
  localparam int MaxWidthDef  = 64;
  localparam int MaxHeightDef = 64;
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MASK   = 2'd2;

  // Hilditch crossing number over p[0..7] (E, NE, N, NW, W, SW, S, SE).
  function automatic logic [2:0] crossing(input logic [7:0] p);
    logic [2:0] k;
    begin
      k = 3'd0;
      if (!p[0] && (p[1] || p[2])) k = k + 3'd1;
      if (!p[2] && (p[3] || p[4])) k = k + 3'd1;
      if (!p[4] && (p[5] || p[6])) k = k + 3'd1;
      if (!p[6] && (p[7] || p[0])) k = k + 3'd1;
      crossing = k;
    end
  endfunction
endpackage

// File: rtl/bit_ram.sv
`timescale 1ns / 1ps
// bit_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module bit_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/bit_pix.sv
`timescale 1ns / 1ps
// bit_pix: per-pixel decision unit, shared for every pixel of every pass.
// Depends on bit_pkg.
module bit_pix (
  input  logic [7:0] nb,
  input  logic       self_px,
  input  logic       mark_up,
  input  logic       mark_left,
  output logic       del
);
  import bit_pkg::*;
  logic [3:0] sum;
  logic [7:0] qu, ql;
  always_comb begin
    sum = 4'(nb[0]) + 4'(nb[1]) + 4'(nb[2]) + 4'(nb[3]) + 4'(nb[4]) + 4'(nb[5])
        + 4'(nb[6]) + 4'(nb[7]);
    qu = nb; qu[2] = 1'b0;
    ql = nb; ql[4] = 1'b0;
    del = self_px && sum != 4'd1 && crossing(nb) == 3'd1
        && !(mark_up && crossing(qu) != 3'd1)
        && !(mark_left && crossing(ql) != 3'd1);
  end
endmodule

// File: rtl/binary_image_thinning.sv
`timescale 1ns / 1ps
// binary_image_thinning: top level, sequencer over row RAMs and one pixel unit.
// Depends on bit_pkg, bit_ram, bit_pix.
//
// channel  | signals                              | dir
// in       | in_valid in_ready in_row             | in
// out      | out_valid out_ready out_row out_last | out
// cfg      | cfg_valid cfg_ready cfg_index cfg_data | in
//
// Loading: one row per cycle. Thinning: each row of a pass goes through current and
// next row fetch, one pixel per cycle, and write-back; passes repeat until none
// deletes. Regrowth: per row, each pixel scans (mask/2*2+1)^2 disc offsets.
// Output: each row is held until out_ready.
// Not ready while thinning or emitting. Reset is synchronous, no clearing pass.
module binary_image_thinning #(
  parameter int MaxWidth  = bit_pkg::MaxWidthDef,
  parameter int MaxHeight = bit_pkg::MaxHeightDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_row,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [bit_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [6:0]  cfg_data
);
  import bit_pkg::*;
  localparam int Dep = (MaxHeight > 64) ? 64 : MaxHeight;
  localparam int AW  = $clog2(Dep);
  localparam int XW  = 7;

  localparam logic [3:0] S_LOAD = 4'd0, S_PREP = 4'd1, S_RD = 4'd2, S_RD2 = 4'd3,
    S_PIX = 4'd4, S_WB = 4'd5, S_RG_RD = 4'd6, S_RG_WT = 4'd7, S_RG_PIX = 4'd8,
    S_OUT = 4'd9, S_RG_NX = 4'd10, S_RD3 = 4'd11;

  logic [3:0] state;
  logic [6:0] wreg, hreg;
  logic [3:0] mreg;
  logic [6:0] rows_loaded, rows_loaded_next;
  logic [6:0] weff, heff;
  logic [63:0] wmask;

  always_comb begin
    weff = (wreg == 7'd0) ? 7'd1 : (wreg > 7'(MaxWidth) ? 7'(MaxWidth) : wreg);
    heff = (hreg == 7'd0) ? 7'd1 : (hreg > 7'(Dep) ? 7'(Dep) : hreg);
    wmask = (weff >= 7'd64) ? '1 : ((64'd1 << weff[5:0]) - 64'd1);
  end

  assign rows_loaded_next = (rows_loaded >= heff) ? 7'd1 : rows_loaded + 7'd1;

  // RAMs: original, working
  logic        o_we, k_we;
  logic [AW-1:0] o_wa, k_wa, o_ra, k_ra;
  logic [63:0] o_wd, k_wd, o_rd, k_rd;
  bit_ram #(.Width(64), .Depth(Dep)) u_orig (.clk, .we(o_we), .waddr(o_wa),
    .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));
  bit_ram #(.Width(64), .Depth(Dep)) u_work (.clk, .we(k_we), .waddr(k_wa),
    .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));

  logic [6:0] y, yy;
  logic [XW-1:0] x;
  logic [63:0] rup, rcur, rdn, mup, mcur, orow, acc;
  logic [1:0] fetch;
  logic changed;
  logic [3:0] ri, rj;

  function automatic logic px(input logic [63:0] r, input logic signed [8:0] c,
                              input logic [6:0] w);
    px = (c >= 0 && c < $signed({2'b0, w})) ? r[c[5:0]] : 1'b0;
  endfunction

  logic [7:0] nb;
  logic del;
  logic signed [8:0] xs;
  always_comb begin
    xs = $signed({2'b0, x});
    nb[0] = px(rcur, xs + 9'sd1, weff);
    nb[1] = px(rup, xs + 9'sd1, weff);
    nb[2] = px(rup, xs, weff);
    nb[3] = px(rup, xs - 9'sd1, weff);
    nb[4] = px(rcur, xs - 9'sd1, weff);
    nb[5] = px(rdn, xs - 9'sd1, weff);
    nb[6] = px(rdn, xs, weff);
    nb[7] = px(rdn, xs + 9'sd1, weff);
  end
  bit_pix u_pix (.nb, .self_px(rcur[x[5:0]]), .mark_up(px(mup, xs, weff)),
    .mark_left(px(mcur, xs - 9'sd1, weff)), .del);

  // regrowth offsets
  logic [2:0] rr;
  logic [7:0] lim;
  logic signed [7:0] di, dj;
  logic [7:0] d2;
  logic signed [8:0] ty;
  always_comb begin
    rr  = mreg[3:1];
    lim = 8'(({4'b0, mreg} * {4'b0, mreg}) >> 2);
    di  = $signed({4'b0, ri}) - $signed({5'b0, rr});
    dj  = $signed({4'b0, rj}) - $signed({5'b0, rr});
    d2  = 8'(di * di) + 8'(dj * dj);
    ty  = $signed({2'b0, y}) + 9'(dj);
  end

  logic [6:0] rmax;
  assign rmax = {3'b0, rr, 1'b0};

  assign in_ready  = (state == S_LOAD) && !rst;
  assign cfg_ready = (state == S_LOAD);

  always_comb begin
    o_we = 1'b0; o_wa = rows_loaded[AW-1:0]; o_wd = in_row;
    k_we = 1'b0; k_wa = rows_loaded[AW-1:0]; k_wd = in_row;
    o_ra = y[AW-1:0]; k_ra = y[AW-1:0];
    if (state == S_LOAD && in_valid) begin
      o_we = 1'b1; k_we = 1'b1;
      if (rows_loaded >= heff) begin o_wa = '0; k_wa = '0; end
    end
    if (state == S_RD || state == S_RD2 || state == S_RD3) begin
      k_ra = yy[AW-1:0];
    end
    if (state == S_WB) begin
      k_we = 1'b1; k_wa = y[AW-1:0]; k_wd = rcur & ~mcur & wmask;
    end
    if (state == S_RG_RD) k_ra = ty[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; wreg <= 7'd64; hreg <= 7'd64; mreg <= 4'd1;
      rows_loaded <= '0; out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (cfg_valid) begin
            case (cfg_index)
              CFG_WIDTH:  wreg <= cfg_data;
              CFG_HEIGHT: hreg <= cfg_data;
              CFG_MASK:   mreg <= cfg_data[3:0];
              default: ;
            endcase
          end
          if (in_valid) begin
            if (rows_loaded_next >= heff) begin
              rows_loaded <= '0; y <= '0; changed <= 1'b0; state <= S_PREP;
            end else begin
              rows_loaded <= rows_loaded_next;
            end
          end
        end
        S_PREP: begin
          y <= '0; yy <= '0; changed <= 1'b0; fetch <= 2'd0;
          rup <= '0; mup <= '0; rcur <= '0; rdn <= '0;
          state <= (mreg == 4'd0) ? S_OUT : S_RD;
        end
        // fetch current row y (and below) of working
        S_RD: begin yy <= y; state <= S_RD2; end
        S_RD2: begin yy <= y + 7'd1; state <= S_RD3; end
        S_RD3: begin
          rcur <= k_rd & wmask;
          state <= S_PIX; fetch <= 2'd1;
        end
        S_PIX: begin
          if (fetch == 2'd1) begin
            rdn <= (y + 7'd1 < heff) ? (k_rd & wmask) : '0;
            fetch <= 2'd0; x <= '0; mcur <= '0;
          end else begin
            if (del) begin mcur[x[5:0]] <= 1'b1; changed <= 1'b1; end
            if (x + 7'd1 >= weff) state <= S_WB;
            x <= x + 7'd1;
          end
        end
        S_WB: begin
          if (y + 7'd1 >= heff) begin
            y <= '0; rup <= '0; mup <= '0;
            if (changed) begin changed <= 1'b0; state <= S_RD; end
            else begin
              state <= (mreg > 4'd1) ? S_RG_NX : S_OUT;
            end
          end else begin
            y <= y + 7'd1; rup <= rcur; mup <= mcur; state <= S_RD;
          end
        end
        // regrowth: per row, build acc
        S_RG_NX: begin
          x <= '0; ri <= '0; rj <= '0; yy <= y;
          state <= S_RG_WT; fetch <= 2'd0;
        end
        S_RG_WT: begin
          // wait for original row and fetch first working row
          if (fetch == 2'd0) begin fetch <= 2'd1; end
          else begin orow <= o_rd & wmask; acc <= '0; state <= S_RG_RD; end
        end
        S_RG_RD: state <= S_RG_PIX;
        S_RG_PIX: begin
          if (ty >= 0 && ty < $signed({2'b0, heff}) && {1'b0, d2} < {1'b0, lim} &&
              orow[x[5:0]] && px(k_rd, $signed({2'b0, x}) + 9'(di), weff))
            acc[x[5:0]] <= 1'b1;
          if ({3'b0, ri} >= rmax) begin
            ri <= '0;
            if ({3'b0, rj} >= rmax) begin
              rj <= '0;
              x <= x + 7'd1;
              state <= (x + 7'd1 >= weff) ? S_OUT : S_RG_RD;
            end else begin
              rj <= rj + 4'd1; state <= S_RG_RD;
            end
          end else begin
            ri <= ri + 4'd1; state <= S_RG_RD;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            state <= S_OUT;
            if (fetch != 2'd3) fetch <= 2'd3;
            else begin
              out_valid <= 1'b1;
              out_row <= (mreg == 4'd0) ? (o_rd & wmask)
                       : (mreg > 4'd1) ? ((k_rd | acc) & wmask) : (k_rd & wmask);
              out_last <= (y + 7'd1 >= heff);
            end
          end else if (out_ready) begin
            out_valid <= 1'b0; fetch <= 2'd0;
            if (y + 7'd1 >= heff) state <= S_LOAD;
            else begin
              y <= y + 7'd1;
              state <= (mreg > 4'd1) ? S_RG_NX : S_OUT;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("in_ready during output");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_row))
    else $error("output dropped");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> state == S_LOAD) else $error("cfg outside load");
`endif
endmodule
